@@ hw/rtl/fcsg_pkg.sv @@
`timescale 1ns / 1ps

package fcsg_pkg;

    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 16;
    localparam int LEN_W       = 9;
    localparam int LEN_MAX     = 511;
    localparam int QUEUE_DEPTH = 2;

    // Midpoint decision constants.
    localparam int D_INIT      = 3;
    localparam int D_STEP_DIAG = 10;
    localparam int D_STEP_AXIS = 6;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        ROW_POS_Y = 2'd0,
        ROW_NEG_Y = 2'd1,
        ROW_POS_X = 2'd2,
        ROW_NEG_X = 2'd3
    } t_row_sel;

endpackage

@@ hw/rtl/fcsg_front.sv @@
`timescale 1ns / 1ps

module fcsg_front #(
    parameter int RADIUS_BITS = 8,
    parameter int REC_W       = 2 * (RADIUS_BITS + 2) + 49
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_kind,
    input  logic [fcsg_pkg::COORD_W-1:0] i_center_x,
    input  logic [fcsg_pkg::COORD_W-1:0] i_center_y,
    input  logic [7:0]                   i_radius,
    input  logic [fcsg_pkg::COLOR_W-1:0] i_fill_color,
    output logic                         o_q_push,
    output logic [REC_W-1:0]             o_q_data
);
    import fcsg_pkg::*;

    localparam int HW = RADIUS_BITS + 2;
    localparam int DW = RADIUS_BITS + 5;

    logic                     r_active;
    logic signed [HW-1:0]     r_x;
    logic signed [HW-1:0]     r_y;
    logic signed [DW-1:0]     r_d;
    logic [COORD_W-1:0]       r_cc;
    logic [COORD_W-1:0]       r_cr;
    logic [COLOR_W-1:0]       r_fill;

    logic                     n_active;
    logic signed [HW-1:0]     n_x;
    logic signed [HW-1:0]     n_y;
    logic signed [DW-1:0]     n_d;
    logic [COORD_W-1:0]       n_cc;
    logic [COORD_W-1:0]       n_cr;
    logic [COLOR_W-1:0]       n_fill;

    logic [RADIUS_BITS-1:0]   w_r;
    logic signed [HW-1:0]     w_adv_x;
    logic signed [HW-1:0]     w_adv_y;
    logic signed [HW-1:0]     w_diff;
    logic signed [DW-1:0]     w_adv_d;
    logic                     w_done;
    logic                     w_push;

    assign w_r     = RADIUS_BITS'(i_radius);
    assign w_adv_x = r_x + HW'(1);
    assign w_adv_y = (r_d > 0) ? (r_y - HW'(1)) : r_y;
    assign w_diff  = w_adv_x - w_adv_y;

    always_comb begin
        if (r_d > 0) begin
            w_adv_d = r_d + (DW'(w_diff) <<< 2) + DW'(D_STEP_DIAG);
        end else begin
            w_adv_d = r_d + (DW'(w_adv_x) <<< 2) + DW'(D_STEP_AXIS);
        end
    end

    always_comb begin
        n_active = r_active;
        n_x      = r_x;
        n_y      = r_y;
        n_d      = r_d;
        n_cc     = r_cc;
        n_cr     = r_cr;
        n_fill   = r_fill;
        w_done   = 1'b0;
        w_push   = 1'b0;
        if (i_accept && (i_kind == KIND_START)) begin
            n_active = 1'b1;
            n_x      = '0;
            n_y      = $signed({2'b00, w_r});
            n_d      = DW'(D_INIT) - DW'({w_r, 1'b0});
            n_cc     = i_center_x;
            n_cr     = i_center_y;
            n_fill   = i_fill_color;
            w_push   = 1'b1;
        end else if (i_accept && r_active) begin
            w_done   = (w_adv_y < w_adv_x);
            n_active = !w_done;
            n_x      = w_adv_x;
            n_y      = w_adv_y;
            n_d      = w_adv_d;
            w_push   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_d      <= '0;
            r_cc     <= '0;
            r_cr     <= '0;
            r_fill   <= '0;
        end else begin
            r_active <= n_active;
            r_x      <= n_x;
            r_y      <= n_y;
            r_d      <= n_d;
            r_cc     <= n_cc;
            r_cr     <= n_cr;
            r_fill   <= n_fill;
        end
    end

    assign o_q_push = w_push;
    assign o_q_data = {w_done, n_x, n_y, n_cc, n_cr, n_fill};

    // The final step of a circle always leaves no circle behind.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_done) |=> !r_active)
        else $error("circle still active after its final step");

endmodule

@@ hw/rtl/fcsg_queue.sv @@
`timescale 1ns / 1ps

module fcsg_queue #(
    parameter int WIDTH = 69
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    import fcsg_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    logic             w_wr;
    logic             w_rd;

    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_full  = (r_count == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // The front never offers a step record that would be dropped.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("step record pushed into a full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

@@ hw/rtl/fcsg_back.sv @@
`timescale 1ns / 1ps

module fcsg_back #(
    parameter int RADIUS_BITS = 8,
    parameter int REC_W       = 2 * (RADIUS_BITS + 2) + 49
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [REC_W-1:0]             i_q_data,
    input  logic                         i_q_empty,
    output logic                         o_q_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic [fcsg_pkg::COORD_W-1:0] o_row_y,
    output logic [fcsg_pkg::COORD_W-1:0] o_left_edge_x,
    output logic [fcsg_pkg::COORD_W-1:0] o_right_edge_x,
    output logic [fcsg_pkg::COORD_W-1:0] o_fill_start_x,
    output logic [fcsg_pkg::LEN_W-1:0]   o_fill_length,
    output logic [fcsg_pkg::COLOR_W-1:0] o_span_color,
    output logic                         o_group_last,
    output logic                         o_circle_done
);
    import fcsg_pkg::*;

    localparam int HW = RADIUS_BITS + 2;
    localparam int LW = (HW + 1 > LEN_W) ? HW + 1 : LEN_W;
    localparam logic signed [HW-1:0] H_ONE = HW'(1);

    t_row_sel                 r_row;
    t_row_sel                 n_row;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [COORD_W-1:0]       r_row_y;
    logic [COORD_W-1:0]       r_left;
    logic [COORD_W-1:0]       r_right;
    logic [COORD_W-1:0]       r_fill_start;
    logic [LEN_W-1:0]         r_len;
    logic [COLOR_W-1:0]       r_color;
    logic                     r_last;
    logic                     r_done;

    logic                     w_rec_done;
    logic signed [HW-1:0]     w_rec_x;
    logic signed [HW-1:0]     w_rec_y;
    logic [COORD_W-1:0]       w_rec_cc;
    logic [COORD_W-1:0]       w_rec_cr;
    logic [COLOR_W-1:0]       w_rec_fill;

    logic signed [HW-1:0]     w_dy;
    logic signed [HW-1:0]     w_h;
    logic [COORD_W-1:0]       w_dy16;
    logic [COORD_W-1:0]       w_h16;
    logic [COORD_W-1:0]       w_left;
    logic [LW-1:0]            w_len_full;
    logic [LEN_W-1:0]         w_len;
    logic                     w_last;
    logic                     w_load;

    assign {w_rec_done, w_rec_x, w_rec_y, w_rec_cc, w_rec_cr, w_rec_fill} = i_q_data;

    assign w_load  = !i_q_empty && (!r_out_valid || pop);
    assign w_last  = (r_row == ROW_NEG_X);
    assign o_q_pop = w_load && w_last;

    always_comb begin
        n_row = r_row;
        if (w_load) begin
            case (r_row)
                ROW_POS_Y: n_row = ROW_NEG_Y;
                ROW_NEG_Y: n_row = ROW_POS_X;
                ROW_POS_X: n_row = ROW_NEG_X;
                ROW_NEG_X: n_row = ROW_POS_Y;
                default:   n_row = ROW_POS_Y;
            endcase
        end
    end

    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_comb begin
        case (r_row)
            ROW_POS_Y: begin
                w_dy = w_rec_y;
                w_h  = w_rec_x;
            end
            ROW_NEG_Y: begin
                w_dy = -w_rec_y;
                w_h  = w_rec_x;
            end
            ROW_POS_X: begin
                w_dy = w_rec_x;
                w_h  = w_rec_y;
            end
            ROW_NEG_X: begin
                w_dy = -w_rec_x;
                w_h  = w_rec_y;
            end
            default: begin
                w_dy = w_rec_y;
                w_h  = w_rec_x;
            end
        endcase
    end

    assign w_dy16     = COORD_W'(w_dy);
    assign w_h16      = COORD_W'(w_h);
    assign w_left     = w_rec_cc - w_h16;
    assign w_len_full = (LW'(w_h) << 1) - LW'(1);

    always_comb begin
        if (w_h > H_ONE) begin
            if (w_len_full > LW'(LEN_MAX)) begin
                w_len = LEN_W'(LEN_MAX);
            end else begin
                w_len = w_len_full[LEN_W-1:0];
            end
        end else begin
            w_len = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= ROW_POS_Y;
            r_out_valid <= 1'b0;
        end else begin
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_row_y      <= w_rec_cr + w_dy16;
            r_left       <= w_left;
            r_right      <= w_rec_cc + w_h16;
            r_fill_start <= w_left + COORD_W'(1);
            r_len        <= w_len;
            r_color      <= w_rec_fill;
            r_last       <= w_last;
            r_done       <= w_rec_done;
        end
    end

    assign empty          = !r_out_valid;
    assign o_row_y        = r_row_y;
    assign o_left_edge_x  = r_left;
    assign o_right_edge_x = r_right;
    assign o_fill_start_x = r_fill_start;
    assign o_fill_length  = r_len;
    assign o_span_color   = r_color;
    assign o_group_last   = r_last;
    assign o_circle_done  = r_done;

    // While the fourth row of a step waits, the row counter is back at the first row.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> (r_row == ROW_POS_Y))
        else $error("row counter out of step with the last row");

endmodule

@@ hw/rtl/filled_circle_span_generator_top.sv @@
`timescale 1ns / 1ps

// Filled circle span generator, midpoint method.
// Input words enter through push/full: a start word (kind 0) latches the
// centre, radius and fill color and makes the first octant step; an advance
// word (kind 1) makes the next step and is dropped when no circle is active.
// Every step yields four row words on the result side, read through
// empty/pop; the oldest word sits on the o_ ports while empty is low.
// The edge color register is written through i_cfg_wr_en/i_cfg_wr_data
// and is held on o_edge_color for the pixel writer.
// A step record passes the step queue and then the output register before
// its first row is on the ports; the row expander then emits the rest one
// row per cycle while pop is held. A two-entry step queue lets the front
// take the next word while rows of the previous step are still going out.
// When the receiver stalls, the output word holds, the queue fills and full
// rises; nothing is lost. Reset leaves no active circle, an empty queue and
// output, and an edge color of zero.
module filled_circle_span_generator_top #(
    parameter int RADIUS_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         i_kind,
    input  logic [fcsg_pkg::COORD_W-1:0] i_center_x,
    input  logic [fcsg_pkg::COORD_W-1:0] i_center_y,
    input  logic [7:0]                   i_radius,
    input  logic [fcsg_pkg::COLOR_W-1:0] i_fill_color,
    input  logic                         i_cfg_wr_en,
    input  logic [fcsg_pkg::COLOR_W-1:0] i_cfg_wr_data,
    output logic [fcsg_pkg::COLOR_W-1:0] o_edge_color,
    output logic                         empty,
    input  logic                         pop,
    output logic [fcsg_pkg::COORD_W-1:0] o_row_y,
    output logic [fcsg_pkg::COORD_W-1:0] o_left_edge_x,
    output logic [fcsg_pkg::COORD_W-1:0] o_right_edge_x,
    output logic [fcsg_pkg::COORD_W-1:0] o_fill_start_x,
    output logic [fcsg_pkg::LEN_W-1:0]   o_fill_length,
    output logic [fcsg_pkg::COLOR_W-1:0] o_span_color,
    output logic                         o_group_last,
    output logic                         o_circle_done
);
    import fcsg_pkg::*;

    localparam int REC_W = 2 * (RADIUS_BITS + 2) + 1 + 2 * COORD_W + COLOR_W;

    logic [COLOR_W-1:0] r_edge_color;

    logic               w_accept;
    logic               w_q_push;
    logic [REC_W-1:0]   w_q_wdata;
    logic [REC_W-1:0]   w_q_rdata;
    logic               w_q_pop;
    logic               w_q_full;
    logic               w_q_empty;

    assign w_accept     = push && !w_q_full;
    assign full         = w_q_full;
    assign o_edge_color = r_edge_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_color <= '0;
        end else if (i_cfg_wr_en) begin
            r_edge_color <= i_cfg_wr_data;
        end
    end

    fcsg_front #(
        .RADIUS_BITS (RADIUS_BITS),
        .REC_W       (REC_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_kind       (i_kind),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius     (i_radius),
        .i_fill_color (i_fill_color),
        .o_q_push     (w_q_push),
        .o_q_data     (w_q_wdata)
    );

    fcsg_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    fcsg_back #(
        .RADIUS_BITS (RADIUS_BITS),
        .REC_W       (REC_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_data       (w_q_rdata),
        .i_q_empty      (w_q_empty),
        .o_q_pop        (w_q_pop),
        .pop            (pop),
        .empty          (empty),
        .o_row_y        (o_row_y),
        .o_left_edge_x  (o_left_edge_x),
        .o_right_edge_x (o_right_edge_x),
        .o_fill_start_x (o_fill_start_x),
        .o_fill_length  (o_fill_length),
        .o_span_color   (o_span_color),
        .o_group_last   (o_group_last),
        .o_circle_done  (o_circle_done)
    );

endmodule
